FILE: design/eoq_pkg.sv
// shared types and constants for the elevator order queue
package eoq_pkg;

    localparam int FLOORS = 4;
    localparam int CNT_W  = $clog2(FLOORS + 1);
    localparam int IDX_W  = $clog2(FLOORS);

    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic do_add;
        logic pop_clear;
        logic pop_start;
        logic pop_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pop_mode;
        logic count_zero;
        logic count_one;
        logic walk_more;
    } dp_status_t;

endpackage

FILE: design/eoq_ctrl.sv
// controller state machine for the elevator order queue
module eoq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  eoq_pkg::dp_status_t status,
    output eoq_pkg::dp_cmd_t    cmd
);

    eoq_pkg::ctrl_state_t state_reg;
    eoq_pkg::ctrl_state_t state_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= eoq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            eoq_pkg::ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = eoq_pkg::ST_EXEC;
                end
            end
            eoq_pkg::ST_EXEC:
            begin
                if (!status.pop_mode)
                begin
                    cmd.do_add = 1'b1;
                    state_next = eoq_pkg::ST_DONE;
                end
                else if (status.count_zero)
                begin
                    state_next = eoq_pkg::ST_DONE;
                end
                else if (status.count_one)
                begin
                    cmd.pop_clear = 1'b1;
                    state_next    = eoq_pkg::ST_DONE;
                end
                else
                begin
                    cmd.pop_start = 1'b1;
                    state_next    = eoq_pkg::ST_WALK;
                end
            end
            eoq_pkg::ST_WALK:
            begin
                if (status.walk_more)
                begin
                    cmd.pop_step = 1'b1;
                end
                else
                begin
                    state_next = eoq_pkg::ST_DONE;
                end
            end
            eoq_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = eoq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eoq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eoq_pkg::ST_IDLE && s_valid) |=> (state_reg == eoq_pkg::ST_EXEC))
        else $error("accepted request did not start execution");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eoq_pkg::ST_WALK && !status.walk_more) |=>
        (state_reg == eoq_pkg::ST_DONE))
        else $error("rebuild walk did not finish");

endmodule

FILE: design/eoq_datapath.sv
// order list, rebuild scratch and result register for the elevator order queue
module eoq_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  eoq_pkg::dp_cmd_t             cmd,
    output eoq_pkg::dp_status_t          status,
    input  logic                         in_mode,
    input  logic [1:0]                   in_floor,
    input  logic [1:0]                   in_direction,
    input  logic [1:0]                   in_current,
    input  logic                         in_at,
    output logic                         out_head_valid,
    output logic [1:0]                   out_head_floor,
    output logic [1:0]                   out_head_direction,
    output logic [2:0]                   out_count
);

    logic                      mode_reg;
    logic [1:0]                floor_reg;
    logic [1:0]                dir_reg;
    logic [1:0]                cur_reg;
    logic                      at_reg;

    logic [1:0]                ent_floor_reg [eoq_pkg::FLOORS];
    logic [1:0]                ent_floor_next [eoq_pkg::FLOORS];
    logic [1:0]                ent_dir_reg [eoq_pkg::FLOORS];
    logic [1:0]                ent_dir_next [eoq_pkg::FLOORS];
    logic [1:0]                scr_floor_reg [eoq_pkg::FLOORS];
    logic [1:0]                scr_dir_reg [eoq_pkg::FLOORS];
    logic [eoq_pkg::CNT_W-1:0] count_reg;
    logic [eoq_pkg::CNT_W-1:0] count_next;
    logic [eoq_pkg::CNT_W-1:0] idx_reg;
    logic [eoq_pkg::CNT_W-1:0] idx_next;
    logic [eoq_pkg::CNT_W-1:0] n_reg;
    logic [eoq_pkg::CNT_W-1:0] n_next;

    logic                      head_valid_reg;
    logic [1:0]                head_floor_reg;
    logic [1:0]                head_dir_reg;
    logic [2:0]                out_count_reg;

    logic [1:0]                add_floor;
    logic [1:0]                add_dir;
    logic                      add_at;
    logic [eoq_pkg::FLOORS-1:0] match;
    logic [eoq_pkg::FLOORS-1:0] seen_before;
    logic                      has_match;
    logic                      on_way;
    logic [1:0]                head_fl;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            floor_reg <= in_floor;
            dir_reg   <= in_direction;
            cur_reg   <= in_current;
            at_reg    <= in_at;
        end
    end

    always_comb
    begin
        add_floor = cmd.pop_step ? scr_floor_reg[idx_reg[eoq_pkg::IDX_W-1:0]] : floor_reg;
        add_dir   = cmd.pop_step ? scr_dir_reg[idx_reg[eoq_pkg::IDX_W-1:0]] : dir_reg;
        add_at    = cmd.pop_step ? 1'b1 : at_reg;
        head_fl   = ent_floor_reg[0];
        for (int k = 0; k < eoq_pkg::FLOORS; k++)
        begin
            match[k] = (eoq_pkg::CNT_W'(k) < count_reg) && (ent_floor_reg[k] == add_floor);
        end
        seen_before[0] = 1'b0;
        for (int k = 1; k < eoq_pkg::FLOORS; k++)
        begin
            seen_before[k] = seen_before[k-1] | match[k-1];
        end
        has_match = |match;
        on_way = (cur_reg < add_floor && add_floor < head_fl && add_dir != eoq_pkg::DIR_DOWN) ||
                 (cur_reg > add_floor && add_floor > head_fl && add_dir != eoq_pkg::DIR_UP) ||
                 (add_at && add_floor == cur_reg);
    end

    always_comb
    begin
        ent_floor_next = ent_floor_reg;
        ent_dir_next   = ent_dir_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        if (cmd.do_add || cmd.pop_step)
        begin
            if (count_reg == '0)
            begin
                ent_floor_next[0] = add_floor;
                ent_dir_next[0]   = add_dir;
                count_next        = eoq_pkg::CNT_W'(1);
            end
            else if (on_way)
            begin
                // insert at head, drop the later order for the same floor
                ent_floor_next[0] = add_floor;
                ent_dir_next[0]   = add_dir;
                for (int k = 1; k < eoq_pkg::FLOORS; k++)
                begin
                    ent_floor_next[k] = seen_before[k] ? ent_floor_reg[k] : ent_floor_reg[k-1];
                    ent_dir_next[k]   = seen_before[k] ? ent_dir_reg[k] : ent_dir_reg[k-1];
                end
                if (!has_match)
                begin
                    count_next = count_reg + eoq_pkg::CNT_W'(1);
                end
            end
            else if (!has_match)
            begin
                ent_floor_next[count_reg[eoq_pkg::IDX_W-1:0]] = add_floor;
                ent_dir_next[count_reg[eoq_pkg::IDX_W-1:0]]   = add_dir;
                count_next = count_reg + eoq_pkg::CNT_W'(1);
            end
        end
        if (cmd.pop_step)
        begin
            idx_next = idx_reg + eoq_pkg::CNT_W'(1);
        end
        if (cmd.pop_clear)
        begin
            count_next = '0;
        end
        if (cmd.pop_start)
        begin
            ent_floor_next[0] = ent_floor_reg[1];
            ent_dir_next[0]   = ent_dir_reg[1];
            count_next        = eoq_pkg::CNT_W'(1);
            n_next            = count_reg;
            idx_next          = eoq_pkg::CNT_W'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        ent_floor_reg <= ent_floor_next;
        ent_dir_reg   <= ent_dir_next;
        if (cmd.pop_start)
        begin
            scr_floor_reg <= ent_floor_reg;
            scr_dir_reg   <= ent_dir_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            head_valid_reg <= (count_reg != '0);
            head_floor_reg <= (count_reg != '0) ? ent_floor_reg[0] : 2'd0;
            head_dir_reg   <= (count_reg != '0) ? ent_dir_reg[0] : 2'd0;
            out_count_reg  <= 3'(count_reg);
        end
    end

    assign status.pop_mode   = (mode_reg == eoq_pkg::MODE_POP);
    assign status.count_zero = (count_reg == '0);
    assign status.count_one  = (count_reg == eoq_pkg::CNT_W'(1));
    assign status.walk_more  = (idx_reg < n_reg);

    assign out_head_valid     = head_valid_reg;
    assign out_head_floor     = head_floor_reg;
    assign out_head_direction = head_dir_reg;
    assign out_count          = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eoq_pkg::CNT_W'(eoq_pkg::FLOORS))
        else $error("order count beyond floor count");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_start |=> (count_reg == eoq_pkg::CNT_W'(1)))
        else $error("rebuild did not start from one order");

    a_step_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_step |=> (count_reg != '0 && count_reg <= n_reg))
        else $error("rebuild step gave bad count");

endmodule

FILE: design/elevator_order_queue.sv
// top level of the elevator order queue
// add request: after accept the order is inserted in EXEC, then the result is loaded from DONE
// pop request on a queue of at most one order: the queue is emptied in EXEC, then the result is loaded from DONE
// other pop request: EXEC starts a rebuild, WALK re-adds the remaining orders one by one, then DONE loads the result
// a new request is taken only in IDLE, once the previous result has gone into the output register
// reset: queue empty, no result pending
module elevator_order_queue
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // order_floor, order_direction, car_floor, at_floor, pad
    input  logic       s_axis_tuser,  // mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // head_valid, head_floor, head_direction, order_count
);

    eoq_pkg::dp_cmd_t    cmd;
    eoq_pkg::dp_status_t status;
    logic                head_valid;
    logic [1:0]          head_floor;
    logic [1:0]          head_direction;
    logic [2:0]          order_count;

    eoq_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    eoq_datapath u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .in_mode            (s_axis_tuser),
        .in_floor           (s_axis_tdata[1:0]),
        .in_direction       (s_axis_tdata[3:2]),
        .in_current         (s_axis_tdata[5:4]),
        .in_at              (s_axis_tdata[6]),
        .out_head_valid     (head_valid),
        .out_head_floor     (head_floor),
        .out_head_direction (head_direction),
        .out_count          (order_count)
    );

    assign m_axis_tdata = {order_count, head_direction, head_floor, head_valid};

endmodule
